[rtl/core/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define PN3_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pn3 assertion failed");

// Checked at every edge, reset included.
`define PN3_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pn3 assertion failed");

`endif

[rtl/core/pn3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pn3_pkg;

    localparam int COORD_W    = 24;
    localparam int NOISE_W    = 19;
    localparam int CELL_W     = 8;
    localparam int HASH_W     = 4;
    localparam int TABLE_SIZE = 256;
    localparam int CORNERS    = 8;

    typedef logic [COORD_W-1:0]        t_coord;
    typedef logic signed [NOISE_W-1:0] t_noise;
    typedef logic [CELL_W-1:0]         t_cell;
    typedef logic [HASH_W-1:0]         t_hash;

    localparam t_cell PERM [TABLE_SIZE] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,
        8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,
        8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,
        8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
        8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,
        8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,
        8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
        8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,
        8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,
        8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,
        8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,
        8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,
        8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
        8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
        8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,
        8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,
        8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
        8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
        8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,
        8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,
        8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,
        8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

    function automatic t_cell perm_lookup(input t_cell idx);
        return PERM[idx];
    endfunction

endpackage
`default_nettype wire

[rtl/core/pn3_fade.sv]
`timescale 1ns / 1ps
`default_nettype none
// Quintic fade 6t^5 - 15t^4 + 10t^3, four register stages.
module pn3_fade #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [FRAC_BITS-1:0] i_t,
    output logic      [FRAC_BITS:0]   o_fade
);
    import pn3_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int QW = F + 4;
    localparam logic [QW-1:0] FIFTEEN_S = QW'(15) << F;
    localparam logic [QW-1:0] TEN_S     = QW'(10) << F;

    logic [QW-1:0]    t_ext;
    logic [QW-1:0]    k_diff;
    logic [2*F-1:0]   r_tt;
    logic [2*F+3:0]   r_pq;
    logic [F-1:0]     r_t2;
    logic [2*F-1:0]   r_m3;
    logic [QW-1:0]    r_q;
    logic [2*F+3:0]   r_fp;
    logic [F:0]       r_fade;

    assign t_ext  = QW'(i_t);
    assign k_diff = FIFTEEN_S - ((t_ext << 2) + (t_ext << 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tt   <= (2*F)'(i_t) * (2*F)'(i_t);
            r_pq   <= (2*F+4)'(i_t) * (2*F+4)'(k_diff);
            r_t2   <= i_t;
            r_m3   <= (2*F)'(r_tt[2*F-1:F]) * (2*F)'(r_t2);
            r_q    <= TEN_S - r_pq[2*F+3:F];
            r_fp   <= (2*F+4)'(r_m3[2*F-1:F]) * (2*F+4)'(r_q);
            r_fade <= r_fp[2*F:F];
        end
    end

    assign o_fade = r_fade;

endmodule
`default_nettype wire

[rtl/core/pn3_hash.sv]
`timescale 1ns / 1ps
`default_nettype none
// Corner hashing through the permutation ROM, three register stages.
module pn3_hash (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire pn3_pkg::t_cell i_ix,
    input  wire pn3_pkg::t_cell i_iy,
    input  wire pn3_pkg::t_cell i_iz,
    output pn3_pkg::t_hash     o_hash [pn3_pkg::CORNERS]
);
    import pn3_pkg::*;

    t_cell r_a, r_b, r_iz2;
    t_cell r_aa, r_ab, r_ba, r_bb;
    t_hash r_h [CORNERS];
    t_cell base [CORNERS];

    always_comb begin
        for (int i = 0; i < CORNERS; i++) begin
            case (i % 4)
                0:       base[i] = r_aa;
                1:       base[i] = r_ba;
                2:       base[i] = r_ab;
                default: base[i] = r_bb;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= perm_lookup(i_ix) + i_iy;
            r_b   <= perm_lookup(CELL_W'(i_ix + 8'd1)) + i_iy;
            r_iz2 <= i_iz;
            r_aa  <= perm_lookup(r_a) + r_iz2;
            r_ab  <= perm_lookup(CELL_W'(r_a + 8'd1)) + r_iz2;
            r_ba  <= perm_lookup(r_b) + r_iz2;
            r_bb  <= perm_lookup(CELL_W'(r_b + 8'd1)) + r_iz2;
            // upper four corners sit one step further along z
            for (int i = 0; i < CORNERS; i++) begin
                r_h[i] <= t_hash'(perm_lookup(CELL_W'(base[i] + CELL_W'(i / 4))));
            end
        end
    end

    assign o_hash = r_h;

endmodule
`default_nettype wire

[rtl/core/pn3_blend.sv]
`timescale 1ns / 1ps
`default_nettype none
// Corner gradients and the trilinear lerp tree, six register stages.
module pn3_blend #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire pn3_pkg::t_hash              i_hash [pn3_pkg::CORNERS],
    input  wire logic [FRAC_BITS-1:0]        i_frac_x,
    input  wire logic [FRAC_BITS-1:0]        i_frac_y,
    input  wire logic [FRAC_BITS-1:0]        i_frac_z,
    input  wire logic [FRAC_BITS:0]          i_fade_u,
    input  wire logic [FRAC_BITS:0]          i_fade_v,
    input  wire logic [FRAC_BITS:0]          i_fade_w,
    output logic signed [FRAC_BITS+2:0]      o_result
);
    import pn3_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int G_W = F + 3;
    localparam int D_W = F + 4;
    localparam int P_W = 2 * F + 6;

    localparam t_hash GRAD_U_Y  = 4'd8;
    localparam t_hash GRAD_V_Y  = 4'd4;
    localparam t_hash GRAD_V_XA = 4'd12;
    localparam t_hash GRAD_V_XB = 4'd14;

    typedef logic signed [G_W-1:0] t_gv;
    typedef logic signed [D_W-1:0] t_dv;
    typedef logic signed [P_W-1:0] t_prod;
    typedef logic [F:0]            t_wt;

    localparam t_gv ONE_S = G_W'(1) << F;

    function automatic t_gv grad(input t_hash h, input t_gv x, input t_gv y, input t_gv z);
        t_gv gu;
        t_gv gv;
        gu = (h < GRAD_U_Y) ? x : y;
        gv = (h < GRAD_V_Y) ? y : ((h == GRAD_V_XA || h == GRAD_V_XB) ? x : z);
        return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
    endfunction

    function automatic t_prod lmul(input t_wt w, input t_gv a, input t_gv b);
        t_dv d;
        d = t_dv'(b) - t_dv'(a);
        return t_prod'($signed({1'b0, w})) * t_prod'(d);
    endfunction

    t_gv   xs [2];
    t_gv   ys [2];
    t_gv   zs [2];
    t_gv   r_g  [CORNERS];
    t_prod r_pa [4];
    t_gv   r_la [4];
    t_gv   r_l  [4];
    t_prod r_pb [2];
    t_gv   r_lb [2];
    t_gv   r_m  [2];
    t_prod r_pc;
    t_gv   r_lc;
    t_wt   r_v6, r_v7, r_w6, r_w7, r_w8, r_w9;

    always_comb begin
        xs[0] = $signed({3'b000, i_frac_x});
        ys[0] = $signed({3'b000, i_frac_y});
        zs[0] = $signed({3'b000, i_frac_z});
        xs[1] = xs[0] - ONE_S;
        ys[1] = ys[0] - ONE_S;
        zs[1] = zs[0] - ONE_S;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < CORNERS; i++) begin
                r_g[i] <= grad(i_hash[i], xs[i % 2], ys[(i / 2) % 2], zs[i / 4]);
            end
            for (int l = 0; l < 4; l++) begin
                r_pa[l] <= lmul(i_fade_u, r_g[2*l], r_g[2*l+1]);
                r_la[l] <= r_g[2*l];
                r_l[l]  <= r_la[l] + t_gv'(r_pa[l] >>> F);
            end
            r_v6 <= i_fade_v;
            r_w6 <= i_fade_w;
            r_v7 <= r_v6;
            r_w7 <= r_w6;
            for (int m = 0; m < 2; m++) begin
                r_pb[m] <= lmul(r_v7, r_l[2*m], r_l[2*m+1]);
                r_lb[m] <= r_l[2*m];
                r_m[m]  <= r_lb[m] + t_gv'(r_pb[m] >>> F);
            end
            r_w8 <= r_w7;
            r_w9 <= r_w8;
            r_pc <= lmul(r_w9, r_m[0], r_m[1]);
            r_lc <= r_m[0];
        end
    end

    assign o_result = r_lc + t_gv'(r_pc >>> F);

endmodule
`default_nettype wire

[rtl/core/perlin_noise_3d.sv]
`timescale 1ns / 1ps
`default_nettype none
// 3D improved gradient noise, one point per beat. Each coordinate is unsigned
// fixed point with FRAC_BITS fraction bits; the integer bits select the lattice
// cell modulo 256. The result is two's complement with FRAC_BITS fraction bits,
// wrapped to 19 bits. The pipeline takes a new point every cycle unless the
// output stalls; its length is set by the fade curve's three chained
// multiplies plus the three multiply-then-add lerp levels. A stall at the
// output holds the whole pipeline, so nothing is dropped or repeated.
module perlin_noise_3d #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire pn3_pkg::t_coord  i_coord_x,
    input  wire pn3_pkg::t_coord  i_coord_y,
    input  wire pn3_pkg::t_coord  i_coord_z,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output pn3_pkg::t_noise       o_noise_value
);
    import pn3_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int DEPTH = 10;

    typedef logic [F-1:0] t_frac;
    typedef logic signed [F+2:0] t_res;

    logic                   en;
    logic [DEPTH:1]         r_vld;
    logic                   r_out_valid;
    t_noise                 r_noise;
    t_coord                 r_cx, r_cy, r_cz;
    t_frac                  r_fx [2:4];
    t_frac                  r_fy [2:4];
    t_frac                  r_fz [2:4];
    logic [COORD_W+7:0]     ext_x, ext_y, ext_z;
    t_hash                  hash [CORNERS];
    logic [F:0]             fade_u, fade_v, fade_w;
    t_res                   result;
    logic signed [47:0]     result_ext;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[DEPTH-1:1], i_in_valid};
            r_out_valid <= r_vld[DEPTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx    <= i_coord_x;
            r_cy    <= i_coord_y;
            r_cz    <= i_coord_z;
            r_fx[2] <= r_cx[F-1:0];
            r_fy[2] <= r_cy[F-1:0];
            r_fz[2] <= r_cz[F-1:0];
            for (int s = 3; s <= 4; s++) begin
                r_fx[s] <= r_fx[s-1];
                r_fy[s] <= r_fy[s-1];
                r_fz[s] <= r_fz[s-1];
            end
            r_noise <= t_noise'(result_ext[NOISE_W-1:0]);
        end
    end

    // cell index: integer bits modulo 256, zero when no integer bits remain
    assign ext_x = {8'b0, r_cx} >> F;
    assign ext_y = {8'b0, r_cy} >> F;
    assign ext_z = {8'b0, r_cz} >> F;

    pn3_hash u_hash (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ix   (ext_x[CELL_W-1:0]),
        .i_iy   (ext_y[CELL_W-1:0]),
        .i_iz   (ext_z[CELL_W-1:0]),
        .o_hash (hash)
    );

    pn3_fade #(.FRAC_BITS(F)) u_fade_x (
        .i_clk(i_clk), .i_en(en), .i_t(r_cx[F-1:0]), .o_fade(fade_u)
    );
    pn3_fade #(.FRAC_BITS(F)) u_fade_y (
        .i_clk(i_clk), .i_en(en), .i_t(r_cy[F-1:0]), .o_fade(fade_v)
    );
    pn3_fade #(.FRAC_BITS(F)) u_fade_z (
        .i_clk(i_clk), .i_en(en), .i_t(r_cz[F-1:0]), .o_fade(fade_w)
    );

    pn3_blend #(.FRAC_BITS(F)) u_blend (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_hash   (hash),
        .i_frac_x (r_fx[4]),
        .i_frac_y (r_fy[4]),
        .i_frac_z (r_fz[4]),
        .i_fade_u (fade_u),
        .i_fade_v (fade_v),
        .i_fade_w (fade_w),
        .o_result (result)
    );

    assign result_ext    = 48'(result);
    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_noise;

endmodule
`default_nettype wire

[rtl/core/pn3_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pn3_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            o_in_ready,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire pn3_pkg::t_noise o_noise_value
);
    // input side only backs up behind a result that is waiting
    `PN3_ASSERT(a_ready_stall, i_clk, i_rst_n, !o_in_ready |-> (o_out_valid && !i_out_ready))
    // a held result keeps its value
    `PN3_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_noise_value)))
    // an offered input beat stays offered until taken
    `PN3_ASSERT(a_in_hold, i_clk, i_rst_n, (i_in_valid && !o_in_ready) |=> i_in_valid)
    // reset clears any waiting result
    `PN3_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)
    `PN3_ASSERT_ALWAYS(a_reset_ready, i_clk, !i_rst_n |=> o_in_ready)
endmodule

bind perlin_noise_3d pn3_checker u_pn3_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_noise_value (o_noise_value)
);
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import pn3_pkg::*;

    localparam int FRAC     = 16;
    localparam int LATENCY  = 10;
    localparam longint ONE  = 64'sd1 <<< FRAC;
    localparam int LIMIT    = 400000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   out_ready = 1'b0;
    t_coord cx = '0, cy = '0, cz = '0;
    logic   in_ready, out_valid;
    t_noise noise;

    perlin_noise_3d #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_coord_x(cx), .i_coord_y(cy), .i_coord_z(cz),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_noise_value(noise)
    );

    initial forever #5 i_clk = ~i_clk;

    t_noise expected_noise[$];
    int     errors = 0;
    int     points_sent = 0;
    int     results_seen = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     cycles = 0;

    // floor division by 2^FRAC for signed values
    function automatic longint fx_floor(longint v);
        if (v >= 0) return v >>> FRAC;
        return -((-v + ONE - 1) >>> FRAC);
    endfunction

    function automatic longint fade_curve(longint t);
        longint t2, t3, q;
        t2 = (t * t) >>> FRAC;
        t3 = (t2 * t) >>> FRAC;
        q  = 10 * ONE - ((15 * ONE * t - 6 * t * t) >>> FRAC);
        return (t3 * q) >>> FRAC;
    endfunction

    function automatic longint blend(longint w, longint a, longint b);
        return a + fx_floor(w * (b - a));
    endfunction

    function automatic longint corner_dot(t_cell hash, longint x, longint y, longint z);
        logic [3:0] h;
        longint u, v;
        h = hash[3:0];
        u = (h < 8) ? x : y;
        v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic t_cell hash_at(int idx);
        t_cell i8;
        i8 = idx[7:0];
        return PERM[i8];
    endfunction

    function automatic t_noise noise_at(t_coord px, t_coord py, t_coord pz);
        int ix, iy, iz, a, aa, ab, b, ba, bb;
        longint x, y, z, u, v, w, l0, l1, l2, l3, r;
        ix = px[23:16]; iy = py[23:16]; iz = pz[23:16];
        x = px[15:0]; y = py[15:0]; z = pz[15:0];
        u = fade_curve(x); v = fade_curve(y); w = fade_curve(z);
        a  = hash_at(ix) + iy;
        aa = hash_at(a) + iz;
        ab = hash_at(a + 1) + iz;
        b  = hash_at(ix + 1) + iy;
        ba = hash_at(b) + iz;
        bb = hash_at(b + 1) + iz;
        l0 = blend(u, corner_dot(hash_at(aa), x, y, z),
                      corner_dot(hash_at(ba), x - ONE, y, z));
        l1 = blend(u, corner_dot(hash_at(ab), x, y - ONE, z),
                      corner_dot(hash_at(bb), x - ONE, y - ONE, z));
        l2 = blend(u, corner_dot(hash_at(aa + 1), x, y, z - ONE),
                      corner_dot(hash_at(ba + 1), x - ONE, y, z - ONE));
        l3 = blend(u, corner_dot(hash_at(ab + 1), x, y - ONE, z - ONE),
                      corner_dot(hash_at(bb + 1), x - ONE, y - ONE, z - ONE));
        r = blend(w, blend(v, l0, l1), blend(v, l2, l3));
        return r[NOISE_W-1:0];
    endfunction

    // valid drops only while idling or draining, so back-to-back beats keep it high
    task automatic send_point(t_coord px, t_coord py, t_coord pz);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        cx <= px; cy <= py; cz <= pz;
        expected_noise.push_back(noise_at(px, py, pz));
        do @(posedge i_clk); while (!in_ready);
        points_sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_noise.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall pattern and result checking
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_noise.size() == 0) begin
                    $error("noise_value: unexpected beat, actual %0d", noise);
                    errors++;
                end else begin
                    t_noise want;
                    want = expected_noise.pop_front();
                    if (noise !== want) begin
                        $error("noise_value: expected %0d actual %0d", want, noise);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(5))
            0: return {8'($urandom_range(255)), 16'h0000};
            1: return {8'($urandom), 16'hFFFF};
            2: return {8'($urandom), 16'(ONE / 2)};
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_corners;
        t_coord edges[6] = '{24'h000000, 24'hFFFFFF, 24'h00FFFF, 24'hFF0000,
                             24'h008000, 24'h7F0001};
        for (int k = 0; k < 6; k++)
            send_point(edges[k], edges[(k + 1) % 6], edges[(k + 3) % 6]);
        send_point(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_point(24'h000000, 24'h000000, 24'h000000);
        // cell wraps: 255 and 0 share neighbors
        send_point(24'hFF4000, 24'h00C000, 24'hFF2000);
        // sixteen cells stepped to spread the gradient codes across the low hash bits
        for (int k = 0; k < 16; k++)
            send_point({8'(k), 16'h3000}, {8'(k * 7), 16'hA000}, {8'(k * 13), 16'h5555});
        drain();
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++) begin
            send_point(rand_coord(), rand_coord(), rand_coord());
            if (k == count / 2) drain();
        end
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 21; recv_idle_pct = 52;
        test_corners();
        test_random(250);
        send_idle_pct = 52; recv_idle_pct = 21;
        test_random(250);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(250);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (expected_noise.size() != 0) begin
            $error("noise_value: %0d results never arrived", expected_noise.size());
            errors++;
        end
        $display("Sent %0d points (edges, cell wrap, all gradient codes, random)", points_sent);
        $display("under three stall mixes; %0d results checked", results_seen);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

[perlin_noise_3d.f]
+incdir+rtl/core
rtl/core/pn3_pkg.sv
rtl/core/pn3_fade.sv
rtl/core/pn3_hash.sv
rtl/core/pn3_blend.sv
rtl/core/perlin_noise_3d.sv
rtl/core/pn3_checker.sv
test/testbench.sv
